// ===== rtl/core/crbp_pkg.sv =====
// ----------------------------------------------------------------------------
// crbp_pkg
// shared constants and types of the csr row block partitioner
// ----------------------------------------------------------------------------
package crbp_pkg;

    localparam int unsigned PTR_W    = 31;
    localparam int unsigned ROW_W    = 32;
    localparam int unsigned SUM_W    = 34;
    localparam int unsigned WORD_W   = 64;
    localparam int unsigned BS_W     = 21;
    localparam int unsigned THR_W    = 16;
    localparam int unsigned VSF_W    = 7;
    localparam int unsigned WG_W     = 6;
    localparam int unsigned RWL_W    = 5;
    localparam int unsigned DIV_W    = BS_W + VSF_W;
    localparam int unsigned CFG_A_W  = 3;

    localparam logic [WG_W-1:0] WG_LIMIT = 6'd60;

    typedef enum logic [CFG_A_W-1:0] {
        CFG_BLOCK_SIZE   = 3'd0,
        CFG_LONG_THRESH  = 3'd1,
        CFG_SHORT_THRESH = 3'd2,
        CFG_VEC_SPLIT    = 3'd3,
        CFG_MAX_WG       = 3'd4,
        CFG_REDUCE_LOG2  = 3'd5
    } t_cfg_idx;

endpackage

// ===== rtl/core/crbp_tc_unit.sv =====
// ----------------------------------------------------------------------------
// crbp_tc_unit
// reduction thread count, one bit of the row span per cycle
// ----------------------------------------------------------------------------
module crbp_tc_unit
    import crbp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [ROW_W-1:0] i_span_m1,
    input  logic [RWL_W-1:0] i_rwl,
    output logic             o_done,
    output logic [ROW_W-1:0] o_count
);

    logic             r_busy;
    logic [ROW_W-1:0] r_m;
    logic [ROW_W-1:0] r_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_m == '0) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_m <= i_span_m1;
            r_t <= ROW_W'(1) << i_rwl;
        end else if (r_busy && r_m != '0) begin
            r_m <= r_m >> 1;
            r_t <= r_t >> 1;
        end
    end

    assign o_done  = r_busy && (r_m == '0);
    assign o_count = r_t;

endmodule

// ===== rtl/core/crbp_div_unit.sv =====
// ----------------------------------------------------------------------------
// crbp_div_unit
// saturating workgroup count by repeated compare and subtract
// ----------------------------------------------------------------------------
module crbp_div_unit
    import crbp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [PTR_W-1:0] i_len,
    input  logic [BS_W-1:0]  i_block_size,
    input  logic [VSF_W-1:0] i_vec_split,
    input  logic [WG_W-1:0]  i_limit,
    output logic             o_done,
    output logic [WG_W-1:0]  o_count
);

    logic             r_busy;
    logic             r_mul;
    logic [DIV_W-1:0] r_div;
    logic [PTR_W-1:0] r_rem;
    logic [WG_W-1:0]  r_q;
    logic             w_step;

    assign w_step = (r_q < i_limit) && ({{(PTR_W-DIV_W){1'b0}}, r_div} <= r_rem);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_mul  <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_mul  <= 1'b1;
        end else if (r_mul) begin
            r_mul <= 1'b0;
        end else if (r_busy && !w_step) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_len;
            r_q   <= '0;
        end else if (r_mul) begin
            r_div <= DIV_W'(i_vec_split) * DIV_W'(i_block_size);
        end else if (r_busy && w_step) begin
            r_rem <= r_rem - {{(PTR_W-DIV_W){1'b0}}, r_div};
            r_q   <= r_q + 1'b1;
        end
    end

    assign o_done  = r_busy && !r_mul && !w_step;
    assign o_count = r_q;

endmodule

// ===== rtl/core/csr_row_block_partitioner.sv =====
// ----------------------------------------------------------------------------
// csr_row_block_partitioner
// csr-adaptive row block words from a stream of row pointers
// ----------------------------------------------------------------------------
// One row pointer is taken at a time and the input stays not ready until its
// row is fully processed. Closing a block adds an output word, which waits
// for the output register to drain; for a block of more than one row the
// thread count shifter first walks the bits of the row span less one. A row
// that overflows a block of several rows closes it and is passed again. A
// long row split over workgroups adds a multiply, one compare-subtract step
// per workgroup (up to 60) and a final compare, and then pushes its words.
// A pointer marked last then flushes the held word.
module csr_row_block_partitioner
    import crbp_pkg::*;
#(
    parameter int unsigned ROW_FIELD_SHIFT = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  logic [31:0]        i_s_tdata,   // [30:0] row_ptr
    input  logic               i_s_tuser,   // is_first
    input  logic               i_s_tlast,   // is_last
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output logic [WORD_W-1:0]  o_m_tdata,   // [63:0] block_word
    output logic               o_m_tlast,   // is_final
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CFG_A_W-1:0] i_cfg_addr,
    input  logic [BS_W-1:0]    i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_PASS_A, S_PASS_B, S_TC, S_PUSH,
        S_DIV, S_VPUSH, S_DONE, S_FLUSH, S_FINAL
    } t_state;

    function automatic logic [WORD_W-1:0] f_end_word(input logic [ROW_W-1:0] row);
        f_end_word = {{(WORD_W-ROW_W){1'b0}}, row} << ROW_FIELD_SHIFT;
    endfunction

    // configuration
    logic [BS_W-1:0]  r_bs;
    logic [THR_W-1:0] r_lrt;
    logic [THR_W-1:0] r_srt;
    logic [VSF_W-1:0] r_vsf;
    logic [WG_W-1:0]  r_mwg;
    logic [RWL_W-1:0] r_rwl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bs  <= BS_W'(1024);
            r_lrt <= THR_W'(128);
            r_srt <= THR_W'(32);
            r_vsf <= VSF_W'(3);
            r_mwg <= WG_W'(60);
            r_rwl <= RWL_W'(8);
        end else if (i_cfg_valid) begin
            case (i_cfg_addr)
                CFG_BLOCK_SIZE:   r_bs  <= i_cfg_data;
                CFG_LONG_THRESH:  r_lrt <= i_cfg_data[THR_W-1:0];
                CFG_SHORT_THRESH: r_srt <= i_cfg_data[THR_W-1:0];
                CFG_VEC_SPLIT:    r_vsf <= i_cfg_data[VSF_W-1:0];
                CFG_MAX_WG:       r_mwg <= i_cfg_data[WG_W-1:0];
                CFG_REDUCE_LOG2:  r_rwl <= i_cfg_data[RWL_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // state
    t_state            r_state;
    t_state            r_ret;
    logic [PTR_W-1:0]  r_prev;
    logic [ROW_W-1:0]  r_rc;
    logic [ROW_W-1:0]  r_bsr;
    logic [SUM_W-1:0]  r_sum;
    logic [ROW_W-1:0]  r_lr;
    logic [WORD_W-1:0] r_held;
    logic [PTR_W-1:0]  r_len;
    logic              r_last;
    logic [WORD_W-1:0] r_push_word;
    logic [WG_W-1:0]   r_w;
    logic [WG_W-1:0]   r_n;
    logic              r_m_valid;
    logic [WORD_W-1:0] r_m_data;
    logic              r_m_last;

    logic              w_accept;
    logic              w_slot;
    logic              w_emit;
    logic [PTR_W-1:0]  w_ptr;
    logic [ROW_W-1:0]  w_im1;
    logic [ROW_W-1:0]  w_span;
    logic [SUM_W-1:0]  w_sum_a;
    logic [SUM_W-1:0]  w_bs_ext;
    logic [ROW_W-1:0]  w_lr_inc;
    logic [ROW_W-1:0]  w_lr_n;
    logic              w_to_short;
    logic              w_vec;
    logic              w_stream;
    logic              w_close_go;
    logic [ROW_W-1:0]  w_close_end;
    logic [ROW_W-1:0]  w_close_span;
    t_state            w_close_ret;
    logic              w_tc_start;
    logic              w_tc_done;
    logic [ROW_W-1:0]  w_tc_count;
    logic              w_div_start;
    logic              w_div_done;
    logic [WG_W-1:0]   w_div_q;
    logic [WG_W-1:0]   w_mw;

    assign w_accept = i_s_tvalid && o_s_tready;
    assign w_slot   = !r_m_valid || i_m_tready;
    assign w_emit   = ((r_state == S_PUSH) || (r_state == S_FINAL)) && w_slot;
    assign w_ptr    = i_s_tdata[PTR_W-1:0];
    assign w_im1    = r_rc - 1'b1;
    assign w_span   = r_rc - r_bsr;
    assign w_sum_a  = r_sum + {{(SUM_W-PTR_W){1'b0}}, r_len};
    assign w_bs_ext = {{(SUM_W-BS_W){1'b0}}, r_bs};
    assign w_lr_inc = (r_lr != '1) ? r_lr + 1'b1 : r_lr;
    assign w_mw     = (r_mwg > WG_LIMIT) ? WG_LIMIT : r_mwg;
    assign w_vec    = (w_span == ROW_W'(1)) && (r_sum > w_bs_ext);
    assign w_stream = (w_span > ROW_W'(1)) && (r_sum > w_bs_ext);

    always_comb begin
        w_to_short = 1'b0;
        w_lr_n     = r_lr;
        if ({{(PTR_W-THR_W){1'b0}}, r_lrt} < r_len) begin
            w_lr_n = w_lr_inc;
        end else if (r_lr != '0) begin
            if (r_len < {{(PTR_W-THR_W){1'b0}}, r_srt}) begin
                w_to_short = 1'b1;
            end else begin
                w_lr_n = w_lr_inc;
            end
        end
    end

    always_comb begin
        w_close_go  = 1'b0;
        w_close_end = w_im1;
        w_close_ret = S_DONE;
        case (r_state)
            S_PASS_A: begin
                w_close_go  = w_to_short || ((w_lr_n == ROW_W'(1)) && (w_span > ROW_W'(1)));
                w_close_ret = S_PASS_B;
            end
            S_PASS_B: begin
                if (w_stream) begin
                    w_close_go  = 1'b1;
                    w_close_ret = S_PASS_A;
                end else if (!w_vec && r_sum == w_bs_ext) begin
                    w_close_go  = 1'b1;
                    w_close_end = r_rc;
                end
            end
            S_FLUSH: begin
                w_close_go  = (r_held >> ROW_FIELD_SHIFT) !=
                              (f_end_word(r_rc) >> ROW_FIELD_SHIFT);
                w_close_end = r_rc;
                w_close_ret = S_FINAL;
            end
            default: ;
        endcase
    end

    assign w_close_span = w_close_end - r_bsr;
    assign w_tc_start   = w_close_go && (w_close_span > ROW_W'(1));
    assign w_div_start  = (r_state == S_PASS_B) && w_vec;

    crbp_tc_unit u_tc (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_tc_start),
        .i_span_m1 (w_close_span - 1'b1),
        .i_rwl     (r_rwl),
        .o_done    (w_tc_done),
        .o_count   (w_tc_count)
    );

    crbp_div_unit u_div (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (w_div_start),
        .i_len        (r_len),
        .i_block_size (r_bs),
        .i_vec_split  (r_vsf),
        .i_limit      (w_mw),
        .o_done       (w_div_done),
        .o_count      (w_div_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ret     <= S_IDLE;
            r_prev    <= '0;
            r_rc      <= '0;
            r_bsr     <= '0;
            r_sum     <= '0;
            r_lr      <= '0;
            r_held    <= '0;
            r_last    <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_m_valid <= w_emit || (r_m_valid && !i_m_tready);
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_last <= i_s_tlast;
                        r_prev <= w_ptr;
                        if (i_s_tuser) begin
                            r_rc   <= '0;
                            r_bsr  <= '0;
                            r_sum  <= '0;
                            r_lr   <= '0;
                            r_held <= '0;
                            r_state <= i_s_tlast ? S_FLUSH : S_IDLE;
                        end else begin
                            r_len   <= (w_ptr >= r_prev) ? w_ptr - r_prev : '0;
                            r_rc    <= r_rc + 1'b1;
                            r_state <= S_PASS_A;
                        end
                    end
                end
                S_PASS_A: begin
                    if (w_close_go) begin
                        r_bsr <= w_im1;
                        r_lr  <= w_to_short ? '0 : w_lr_n;
                        r_sum <= {{(SUM_W-PTR_W){1'b0}}, r_len};
                    end else begin
                        r_sum   <= w_sum_a;
                        r_lr    <= w_lr_n;
                        r_state <= S_PASS_B;
                    end
                end
                S_PASS_B: begin
                    if (w_vec) begin
                        r_bsr   <= r_rc;
                        r_sum   <= '0;
                        r_lr    <= '0;
                        r_state <= S_DIV;
                    end else if (w_close_go) begin
                        r_bsr <= w_stream ? w_im1 : r_rc;
                        r_sum <= '0;
                        r_lr  <= '0;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_TC: begin
                    if (w_tc_done) begin
                        r_held  <= r_held | {{(WORD_W-ROW_W){1'b0}}, w_tc_count};
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (w_slot) begin
                        r_m_data  <= r_held;
                        r_m_last  <= 1'b0;
                        r_held    <= r_push_word;
                        r_state   <= r_ret;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_w     <= WG_W'(1);
                        r_n     <= w_div_q;
                        r_state <= S_VPUSH;
                    end
                end
                S_VPUSH: begin
                    if (r_w < r_n) begin
                        r_push_word <= f_end_word(w_im1) | {{(WORD_W-WG_W){1'b0}}, r_w};
                        r_w         <= r_w + 1'b1;
                        r_ret       <= S_VPUSH;
                    end else begin
                        r_push_word <= f_end_word(r_rc);
                        r_ret       <= S_DONE;
                    end
                    r_state <= S_PUSH;
                end
                S_DONE: begin
                    r_sum   <= {1'b0, r_sum[SUM_W-2:0]};
                    r_state <= r_last ? S_FLUSH : S_IDLE;
                end
                S_FLUSH: begin
                    if (!w_close_go) begin
                        r_state <= S_FINAL;
                    end
                end
                S_FINAL: begin
                    if (w_slot) begin
                        r_m_data  <= r_held;
                        r_m_last  <= 1'b1;
                        r_prev    <= '0;
                        r_rc      <= '0;
                        r_bsr     <= '0;
                        r_sum     <= '0;
                        r_lr      <= '0;
                        r_held    <= '0;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (w_close_go) begin
                r_push_word <= f_end_word(w_close_end);
                r_ret       <= w_close_ret;
                r_state     <= w_tc_start ? S_TC : S_PUSH;
            end
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tlast  = r_m_last;

endmodule

// ===== rtl/core/crbp_checker.sv =====
// ----------------------------------------------------------------------------
// crbp_checker
// port level checks of the csr row block partitioner
// ----------------------------------------------------------------------------
module crbp_checker
    import crbp_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_s_tvalid,
    input logic               o_s_tready,
    input logic               i_s_tuser,
    input logic               i_s_tlast,
    input logic               o_m_tvalid,
    input logic               i_m_tready,
    input logic [WORD_W-1:0]  o_m_tdata,
    input logic               o_m_tlast
);

    // row pointer transfer starts a busy period
    a_row_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && !i_s_tuser) |=> !o_s_tready)
        else $error("input ready after a row transfer");

    // first and last together flushes
    a_empty_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && i_s_tuser && i_s_tlast) |=> !o_s_tready)
        else $error("no flush after empty matrix");

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> o_m_tvalid)
        else $error("output valid dropped");

    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> ($stable(o_m_tdata) && $stable(o_m_tlast)))
        else $error("output payload changed while stalled");

endmodule

bind csr_row_block_partitioner crbp_checker u_crbp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_s_tvalid  (i_s_tvalid),
    .o_s_tready  (o_s_tready),
    .i_s_tuser   (i_s_tuser),
    .i_s_tlast   (i_s_tlast),
    .o_m_tvalid  (o_m_tvalid),
    .i_m_tready  (i_m_tready),
    .o_m_tdata   (o_m_tdata),
    .o_m_tlast   (o_m_tlast)
);
